FILE: hdl/lkb_pkg.sv
// Shared types and constants for the look-direction to rotation basis block.
package lkb_pkg;

  // Fixed-point format of the basis elements (Q1.14).
  localparam int FracBits = 14;
  localparam int ElemW    = 16;
  localparam logic [FracBits:0] OneQ = (FracBits + 1)'(1) << FracBits;

  // Normalizer sizes: 16-bit magnitudes, radicand = sum of squares << 28.
  localparam int MagW       = 16;
  localparam int SqW        = 2 * MagW;
  localparam int LenW       = SqW + 2;
  localparam int LenShift   = 28;
  localparam int RadW       = LenW + LenShift + 1;
  localparam int SqSteps    = RadW / 2 + 1;
  localparam int SqPerStage = 2;
  localparam int SqStages   = (SqSteps + SqPerStage - 1) / SqPerStage;
  localparam int RootW      = 31;
  localparam int NumW       = MagW + FracBits + 14 + 2;
  localparam int QuoW       = FracBits + 1;
  localparam int DivPerStage = 2;
  localparam int DivStages  = (QuoW + DivPerStage - 1) / DivPerStage;

  // Cross product widths.
  localparam int ProdW  = 32;
  localparam int CMagW  = 31;
  localparam int ShiftW = 4;

  // Configuration register map.
  localparam int ApbAddrW = 2;
  localparam int ApbDataW = 32;
  localparam int LimW     = 15;
  localparam logic [ApbAddrW-1:0] RegNearZeroAddr = '0;
  localparam logic [LimW-1:0]     LimReset        = LimW'(16);

  // Result status codes.
  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StZeroDir  = 2'd1,
    StParallel = 2'd2
  } status_e;

endpackage

FILE: hdl/lkb_if.sv
// Request and result channel interfaces of the rotation basis block.
interface lkb_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;
  logic signed [15:0] up_x;
  logic signed [15:0] up_y;
  logic signed [15:0] up_z;

  modport source (output valid, dir_x, dir_y, dir_z, up_x, up_y, up_z, input ready);
  modport sink (input valid, dir_x, dir_y, dir_z, up_x, up_y, up_z, output ready);
endinterface

interface lkb_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] xaxis_x;
  logic signed [15:0] xaxis_y;
  logic signed [15:0] xaxis_z;
  logic signed [15:0] yaxis_x;
  logic signed [15:0] yaxis_y;
  logic signed [15:0] yaxis_z;
  logic signed [15:0] zaxis_x;
  logic signed [15:0] zaxis_y;
  logic signed [15:0] zaxis_z;
  logic [1:0]         status;

  modport source (output valid, xaxis_x, xaxis_y, xaxis_z, yaxis_x, yaxis_y, yaxis_z,
                  zaxis_x, zaxis_y, zaxis_z, status, input ready);
  modport sink (input valid, xaxis_x, xaxis_y, xaxis_z, yaxis_x, yaxis_y, yaxis_z,
                zaxis_x, zaxis_y, zaxis_z, status, output ready);
endinterface

FILE: hdl/lkb_norm.sv
// Pipelined vector normalizer: squares, digit-by-digit square root, restoring divide.
module lkb_norm #(
  parameter int SideW = 1
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       en_i,
  input  logic                                       valid_i,
  input  logic [2:0][lkb_pkg::MagW-1:0]              mag_i,
  input  logic [2:0]                                 neg_i,
  input  logic [SideW-1:0]                           side_i,
  output logic                                       valid_o,
  output logic                                       zero_o,
  output logic [2:0][lkb_pkg::ElemW-1:0]             val_o,
  output logic [SideW-1:0]                           side_o
);

  typedef struct packed {
    logic [2:0][lkb_pkg::MagW-1:0] mag;
    logic [2:0]                    neg;
    logic                          zero;
    logic [SideW-1:0]              side;
    logic [lkb_pkg::RadW-1:0]      rem;
    logic [lkb_pkg::RadW-1:0]      root;
  } sq_t;

  typedef struct packed {
    logic [2:0]                    neg;
    logic                          zero;
    logic [SideW-1:0]              side;
    logic [lkb_pkg::RootW-1:0]     s;
    logic [2:0][lkb_pkg::NumW-1:0] rem;
    logic [2:0][lkb_pkg::QuoW-1:0] quo;
  } dv_t;

  logic                              v0_q, v1_q;
  logic [2:0][lkb_pkg::MagW-1:0]     mag0_q, mag1_q;
  logic [2:0]                        neg0_q, neg1_q;
  logic [SideW-1:0]                  side0_q, side1_q;
  logic [2:0][lkb_pkg::SqW-1:0]      sq1_q;

  sq_t  sq_d [lkb_pkg::SqStages+1];
  sq_t  sq_q [lkb_pkg::SqStages+1];
  logic sq_v_q [lkb_pkg::SqStages+1];
  dv_t  dv_d [lkb_pkg::DivStages+1];
  dv_t  dv_q [lkb_pkg::DivStages+1];
  logic dv_v_q [lkb_pkg::DivStages+1];

  logic                              out_v_q, out_zero_q;
  logic [2:0][lkb_pkg::ElemW-1:0]    out_val_q;
  logic [SideW-1:0]                  out_side_q;
  logic [2:0][lkb_pkg::ElemW-1:0]    out_val_d;

  // Sum of squares enters the square root with its fixed left shift.
  // The root then takes two digit steps per stage, bit weight fixed by position.
  always_comb begin
    logic [lkb_pkg::LenW-1:0] len2;
    sq_t t;
    logic [lkb_pkg::RadW-1:0] bitv;
    logic [lkb_pkg::RadW-1:0] trial;
    int st;
    len2 = lkb_pkg::LenW'(sq1_q[0]) + lkb_pkg::LenW'(sq1_q[1]) + lkb_pkg::LenW'(sq1_q[2]);
    sq_d[0].mag  = mag1_q;
    sq_d[0].neg  = neg1_q;
    sq_d[0].side = side1_q;
    sq_d[0].zero = (len2 == '0);
    sq_d[0].rem  = lkb_pkg::RadW'({len2, lkb_pkg::LenShift'(0)});
    sq_d[0].root = '0;
    for (int j = 1; j <= lkb_pkg::SqStages; j++) begin
      t = sq_q[j-1];
      for (int u = 0; u < lkb_pkg::SqPerStage; u++) begin
        st = (j - 1) * lkb_pkg::SqPerStage + u;
        bitv  = lkb_pkg::RadW'(1) << (lkb_pkg::RadW - 1 - 2 * st);
        trial = t.root + bitv;
        if (t.rem >= trial) begin
          t.rem  = t.rem - trial;
          t.root = (t.root >> 1) + bitv;
        end else begin
          t.root = t.root >> 1;
        end
      end
      sq_d[j] = t;
    end
  end

  // Dividend is the scaled magnitude plus half the root for rounding.
  // Restoring division of all three components, two quotient bits per stage.
  always_comb begin
    logic [lkb_pkg::RootW-1:0] s;
    dv_t t;
    logic [lkb_pkg::NumW-1:0] sh;
    int st;
    int b;
    s = sq_q[lkb_pkg::SqStages].root[lkb_pkg::RootW-1:0];
    dv_d[0].neg  = sq_q[lkb_pkg::SqStages].neg;
    dv_d[0].zero = sq_q[lkb_pkg::SqStages].zero;
    dv_d[0].side = sq_q[lkb_pkg::SqStages].side;
    dv_d[0].s    = s;
    dv_d[0].quo  = '0;
    for (int i = 0; i < 3; i++) begin
      dv_d[0].rem[i] = lkb_pkg::NumW'({sq_q[lkb_pkg::SqStages].mag[i],
                                      (lkb_pkg::FracBits + 14)'(0)})
                     + lkb_pkg::NumW'(s >> 1);
    end
    for (int j = 1; j <= lkb_pkg::DivStages; j++) begin
      t = dv_q[j-1];
      for (int u = 0; u < lkb_pkg::DivPerStage; u++) begin
        st = (j - 1) * lkb_pkg::DivPerStage + u;
        if (st < lkb_pkg::QuoW) begin
          b  = lkb_pkg::QuoW - 1 - st;
          sh = lkb_pkg::NumW'(t.s) << b;
          for (int i = 0; i < 3; i++) begin
            if (t.rem[i] >= sh) begin
              t.rem[i]    = t.rem[i] - sh;
              t.quo[i][b] = 1'b1;
            end
          end
        end
      end
      dv_d[j] = t;
    end
  end

  // Saturate to one and apply the sign.
  always_comb begin
    logic [lkb_pkg::QuoW-1:0] q;
    for (int i = 0; i < 3; i++) begin
      q = dv_q[lkb_pkg::DivStages].quo[i];
      if (q > lkb_pkg::OneQ) begin
        q = lkb_pkg::OneQ;
      end
      out_val_d[i] = dv_q[lkb_pkg::DivStages].neg[i] ? -lkb_pkg::ElemW'(q)
                                                     : lkb_pkg::ElemW'(q);
    end
  end

  // Valid bits advance with the global pipeline enable.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q    <= 1'b0;
      v1_q    <= 1'b0;
      out_v_q <= 1'b0;
      for (int j = 0; j <= lkb_pkg::SqStages; j++) sq_v_q[j] <= 1'b0;
      for (int j = 0; j <= lkb_pkg::DivStages; j++) dv_v_q[j] <= 1'b0;
    end else if (en_i) begin
      v0_q      <= valid_i;
      v1_q      <= v0_q;
      sq_v_q[0] <= v1_q;
      for (int j = 1; j <= lkb_pkg::SqStages; j++) sq_v_q[j] <= sq_v_q[j-1];
      dv_v_q[0] <= sq_v_q[lkb_pkg::SqStages];
      for (int j = 1; j <= lkb_pkg::DivStages; j++) dv_v_q[j] <= dv_v_q[j-1];
      out_v_q   <= dv_v_q[lkb_pkg::DivStages];
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag0_q  <= mag_i;
      neg0_q  <= neg_i;
      side0_q <= side_i;
      for (int i = 0; i < 3; i++) sq1_q[i] <= mag0_q[i] * mag0_q[i];
      mag1_q  <= mag0_q;
      neg1_q  <= neg0_q;
      side1_q <= side0_q;
      for (int j = 0; j <= lkb_pkg::SqStages; j++) sq_q[j] <= sq_d[j];
      for (int j = 0; j <= lkb_pkg::DivStages; j++) dv_q[j] <= dv_d[j];
      out_val_q  <= out_val_d;
      out_zero_q <= dv_q[lkb_pkg::DivStages].zero;
      out_side_q <= dv_q[lkb_pkg::DivStages].side;
    end
  end

  assign valid_o = out_v_q;
  assign zero_o  = out_zero_q;
  assign val_o   = out_val_q;
  assign side_o  = out_side_q;

endmodule

FILE: hdl/lkb_cross.sv
// Up vector substitution, cross product up x Z and pre-shift for the second normalizer.
module lkb_cross (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic [lkb_pkg::LimW-1:0]              lim_i,
  input  logic [2:0][lkb_pkg::ElemW-1:0]        z_i,
  input  logic                                  zero_i,
  input  logic [2:0][15:0]                      up_i,
  output logic                                  valid_o,
  output logic [2:0][lkb_pkg::MagW-1:0]         mag_o,
  output logic [2:0]                            neg_o,
  output logic [2:0][lkb_pkg::ElemW-1:0]        z_o,
  output logic                                  zero_o
);

  logic                                 v0_q, v1_q, v2_q, v3_q;
  logic [2:0][15:0]                     u0_q, u0_d;
  logic [2:0][lkb_pkg::ElemW-1:0]       z0_q, z1_q, z2_q, z3_q;
  logic                                 zr0_q, zr1_q, zr2_q, zr3_q;
  logic signed [lkb_pkg::ProdW-1:0]     p1_q [6];
  logic signed [lkb_pkg::ProdW-1:0]     c2_q [3];
  logic [2:0][lkb_pkg::CMagW-1:0]       m3_q, m3_d;
  logic [2:0]                           n3_q;
  logic [lkb_pkg::ShiftW-1:0]           k3_q, k3_d;

  // Replace the up hint when Z is nearly vertical.
  always_comb begin
    logic [lkb_pkg::ElemW-1:0] ax, az;
    logic                      near;
    ax   = z_i[0][lkb_pkg::ElemW-1] ? -z_i[0] : z_i[0];
    az   = z_i[2][lkb_pkg::ElemW-1] ? -z_i[2] : z_i[2];
    near = (ax < lkb_pkg::ElemW'(lim_i)) && (az < lkb_pkg::ElemW'(lim_i));
    u0_d = up_i;
    if (near) begin
      u0_d[0] = '0;
      u0_d[1] = '0;
      u0_d[2] = ($signed(up_i[1]) > 0) ? -z_i[1] : z_i[1];
    end
  end

  // Magnitudes of the cross product and the right shift that fits them in 16 bits.
  always_comb begin
    logic [lkb_pkg::CMagW-1:0] all;
    logic [lkb_pkg::ProdW-1:0] a;
    for (int i = 0; i < 3; i++) begin
      a       = c2_q[i][lkb_pkg::ProdW-1] ? -c2_q[i] : c2_q[i];
      m3_d[i] = a[lkb_pkg::CMagW-1:0];
    end
    all  = m3_d[0] | m3_d[1] | m3_d[2];
    k3_d = '0;
    for (int b = lkb_pkg::MagW; b < lkb_pkg::CMagW; b++) begin
      if (all[b]) k3_d = lkb_pkg::ShiftW'(b - lkb_pkg::MagW + 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Products, differences and magnitudes, one register stage each.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u0_q  <= u0_d;
      z0_q  <= z_i;
      zr0_q <= zero_i;
      p1_q[0] <= $signed(u0_q[1]) * $signed(z0_q[2]);
      p1_q[1] <= $signed(u0_q[2]) * $signed(z0_q[1]);
      p1_q[2] <= $signed(u0_q[2]) * $signed(z0_q[0]);
      p1_q[3] <= $signed(u0_q[0]) * $signed(z0_q[2]);
      p1_q[4] <= $signed(u0_q[0]) * $signed(z0_q[1]);
      p1_q[5] <= $signed(u0_q[1]) * $signed(z0_q[0]);
      z1_q  <= z0_q;
      zr1_q <= zr0_q;
      c2_q[0] <= p1_q[0] - p1_q[1];
      c2_q[1] <= p1_q[2] - p1_q[3];
      c2_q[2] <= p1_q[4] - p1_q[5];
      z2_q  <= z1_q;
      zr2_q <= zr1_q;
      m3_q  <= m3_d;
      for (int i = 0; i < 3; i++) n3_q[i] <= c2_q[i][lkb_pkg::ProdW-1];
      k3_q  <= k3_d;
      z3_q  <= z2_q;
      zr3_q <= zr2_q;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_o[i] = lkb_pkg::MagW'(m3_q[i] >> k3_q);
    end
  end

  assign valid_o = v3_q;
  assign neg_o   = n3_q;
  assign z_o     = z3_q;
  assign zero_o  = zr3_q;

endmodule

FILE: hdl/lkb_yaxis.sv
// Y axis as the rounded cross product Z x X, status selection and the result register.
module lkb_yaxis (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic [2:0][lkb_pkg::ElemW-1:0]        x_i,
  input  logic                                  zero_x_i,
  input  logic [2:0][lkb_pkg::ElemW-1:0]        z_i,
  input  logic                                  zero_z_i,
  output logic                                  valid_o,
  output logic [2:0][lkb_pkg::ElemW-1:0]        x_o,
  output logic [2:0][lkb_pkg::ElemW-1:0]        y_o,
  output logic [2:0][lkb_pkg::ElemW-1:0]        z_o,
  output lkb_pkg::status_e                      status_o
);

  localparam int PW = 2 * lkb_pkg::FracBits + 2;

  logic                              v0_q, v1_q, v2_q;
  logic signed [PW-1:0]              p0_q [6];
  logic [2:0][lkb_pkg::ElemW-1:0]    x0_q, z0_q, x1_q, z1_q;
  lkb_pkg::status_e                  st0_q, st1_q, st0_d;
  logic [2:0][PW-1:0]                m1_q, m1_d;
  logic [2:0]                        n1_q;
  logic [2:0][lkb_pkg::ElemW-1:0]    x2_q, y2_q, z2_q, y2_d;
  lkb_pkg::status_e                  st2_q;

  // A zero direction takes precedence over a parallel up vector.
  always_comb begin
    if (zero_z_i) begin
      st0_d = lkb_pkg::StZeroDir;
    end else if (zero_x_i) begin
      st0_d = lkb_pkg::StParallel;
    end else begin
      st0_d = lkb_pkg::StOk;
    end
  end

  // Magnitudes of the product differences.
  always_comb begin
    logic signed [PW-1:0] d;
    for (int i = 0; i < 3; i++) begin
      d       = p0_q[2*i] - p0_q[2*i+1];
      m1_d[i] = d[PW-1] ? PW'(-d) : PW'(d);
    end
  end

  // Round half away from zero, saturate, restore the sign.
  always_comb begin
    logic [PW-1:0] q;
    for (int i = 0; i < 3; i++) begin
      q = (m1_q[i] + (PW'(1) << (lkb_pkg::FracBits - 1))) >> lkb_pkg::FracBits;
      if (q > PW'(lkb_pkg::OneQ)) q = PW'(lkb_pkg::OneQ);
      y2_d[i] = n1_q[i] ? -lkb_pkg::ElemW'(q) : lkb_pkg::ElemW'(q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q[0] <= PW'($signed(z_i[1]) * $signed(x_i[2]));
      p0_q[1] <= PW'($signed(z_i[2]) * $signed(x_i[1]));
      p0_q[2] <= PW'($signed(z_i[2]) * $signed(x_i[0]));
      p0_q[3] <= PW'($signed(z_i[0]) * $signed(x_i[2]));
      p0_q[4] <= PW'($signed(z_i[0]) * $signed(x_i[1]));
      p0_q[5] <= PW'($signed(z_i[1]) * $signed(x_i[0]));
      x0_q  <= x_i;
      z0_q  <= z_i;
      st0_q <= st0_d;
      m1_q  <= m1_d;
      for (int i = 0; i < 3; i++) n1_q[i] <= p0_q[2*i] < p0_q[2*i+1];
      x1_q  <= x0_q;
      z1_q  <= z0_q;
      st1_q <= st0_q;
      // Any failure clears the whole basis.
      if (st1_q == lkb_pkg::StOk) begin
        x2_q <= x1_q;
        y2_q <= y2_d;
        z2_q <= z1_q;
      end else begin
        x2_q <= '0;
        y2_q <= '0;
        z2_q <= '0;
      end
      st2_q <= st1_q;
    end
  end

  assign valid_o  = v2_q;
  assign x_o      = x2_q;
  assign y_o      = y2_q;
  assign z_o      = z2_q;
  assign status_o = st2_q;

endmodule

FILE: hdl/look_direction_to_rotation_basis_top.sv
// Top level of the look-direction to rotation basis block.
//
// The request channel in_if carries a look direction and an up hint, six signed
// 16-bit components. The result channel out_if returns the X, Y and Z basis
// vectors in Q1.14 and a status: ok, zero direction, or up parallel to the
// direction; on either failure all nine basis elements are zero.
// The user writes the near-zero limit (APB address 0) only while idle; not enforced.
//
// The datapath is one pipeline of 65 register stages under a common enable,
// and one request is taken every cycle unless the receiver holds off a result.
// The depth comes from two normalizers, each a square root at two digits per
// stage followed by a divider at two quotient bits per stage, plus the cross
// product and Y axis stages.
// When the receiver holds off, the whole pipeline freezes and in_if.ready
// drops; the waiting result stays in the output register and nothing is lost.
// Reset empties the pipeline and sets the near-zero limit to 16.
module look_direction_to_rotation_basis_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  lkb_in_if.sink                         in_if,
  lkb_out_if.source                      out_if,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lkb_pkg::ApbAddrW-1:0]   paddr,
  input  logic [lkb_pkg::ApbDataW-1:0]   pwdata,
  output logic [lkb_pkg::ApbDataW-1:0]   prdata,
  output logic                           pready
);

  localparam int UpW = 48;

  logic [lkb_pkg::LimW-1:0]           lim_q;
  logic                               en;
  logic [2:0][15:0]                   dir;
  logic [2:0][lkb_pkg::MagW-1:0]      dmag;
  logic [2:0]                         dneg;
  logic                               n1_valid, n1_zero;
  logic [2:0][lkb_pkg::ElemW-1:0]     z1;
  logic [UpW-1:0]                     n1_up;
  logic                               c_valid, c_zero;
  logic [2:0][lkb_pkg::MagW-1:0]      cmag;
  logic [2:0]                         cneg;
  logic [2:0][lkb_pkg::ElemW-1:0]     cz;
  logic                               n2_valid, n2_zero;
  logic [2:0][lkb_pkg::ElemW-1:0]     x2;
  logic [UpW:0]                       n2_side;
  logic                               y_valid;
  logic [2:0][lkb_pkg::ElemW-1:0]     xo, yo, zo;
  lkb_pkg::status_e                   st;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= lkb_pkg::LimReset;
    end else if (psel && penable && pwrite && (paddr == lkb_pkg::RegNearZeroAddr)) begin
      lim_q <= pwdata[lkb_pkg::LimW-1:0];
    end
  end

  assign prdata = (paddr == lkb_pkg::RegNearZeroAddr) ? lkb_pkg::ApbDataW'(lim_q) : '0;
  assign pready = 1'b1;

  // The pipeline moves whenever the output register is free or being emptied.
  assign en          = !out_if.valid || out_if.ready;
  assign in_if.ready = en;

  // Split the direction into magnitude and sign.
  assign dir = {in_if.dir_z, in_if.dir_y, in_if.dir_x};
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dneg[i] = dir[i][15];
      dmag[i] = dir[i][15] ? -dir[i] : dir[i];
    end
  end

  lkb_norm #(.SideW(UpW)) u_norm_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_if.valid && en),
    .mag_i   (dmag),
    .neg_i   (dneg),
    .side_i  ({in_if.up_z, in_if.up_y, in_if.up_x}),
    .valid_o (n1_valid),
    .zero_o  (n1_zero),
    .val_o   (z1),
    .side_o  (n1_up)
  );

  lkb_cross u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (n1_valid),
    .lim_i   (lim_q),
    .z_i     (z1),
    .zero_i  (n1_zero),
    .up_i    (n1_up),
    .valid_o (c_valid),
    .mag_o   (cmag),
    .neg_o   (cneg),
    .z_o     (cz),
    .zero_o  (c_zero)
  );

  lkb_norm #(.SideW(UpW + 1)) u_norm_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (c_valid),
    .mag_i   (cmag),
    .neg_i   (cneg),
    .side_i  ({c_zero, cz}),
    .valid_o (n2_valid),
    .zero_o  (n2_zero),
    .val_o   (x2),
    .side_o  (n2_side)
  );

  lkb_yaxis u_yaxis (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (n2_valid),
    .x_i      (x2),
    .zero_x_i (n2_zero),
    .z_i      (n2_side[UpW-1:0]),
    .zero_z_i (n2_side[UpW]),
    .valid_o  (y_valid),
    .x_o      (xo),
    .y_o      (yo),
    .z_o      (zo),
    .status_o (st)
  );

  // Result channel.
  assign out_if.valid   = y_valid;
  assign out_if.xaxis_x = xo[0];
  assign out_if.xaxis_y = xo[1];
  assign out_if.xaxis_z = xo[2];
  assign out_if.yaxis_x = yo[0];
  assign out_if.yaxis_y = yo[1];
  assign out_if.yaxis_z = yo[2];
  assign out_if.zaxis_x = zo[0];
  assign out_if.zaxis_y = zo[1];
  assign out_if.zaxis_z = zo[2];
  assign out_if.status  = st;

`ifndef SYNTHESIS
  a_fail_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && (out_if.status != lkb_pkg::StOk) |->
      (out_if.zaxis_x == 0) && (out_if.zaxis_y == 0) && (out_if.zaxis_z == 0) &&
      (out_if.xaxis_x == 0) && (out_if.yaxis_y == 0))
    else $error("failed basis is not cleared");
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (out_if.status != 2'd3))
    else $error("undefined status code");
  a_z_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> ($signed(out_if.zaxis_y) <= 16384) && ($signed(out_if.zaxis_y) >= -16384))
    else $error("Z axis out of range");
  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> !in_if.ready || $past(in_if.ready) == 1'b0 || out_if.valid)
    else $error("stalled result dropped");
`endif

endmodule

FILE: dv/lkb_tb_if.sv
// Testbench request and expected-result types of the rotation basis block.
package lkb_tb_pkg;

  // One request item: look direction and up hint.
  typedef struct packed {
    logic signed [15:0] dx, dy, dz, ux, uy, uz;
  } look_req_t;

  // One expected basis result.
  typedef struct packed {
    logic signed [15:0] xx, xy, xz, yx, yy, yz, zx, zy, zz;
    lkb_pkg::status_e   st;
  } basis_t;
endpackage

FILE: dv/tb.sv
// Self-checking testbench of the look-direction to rotation basis block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 20000;
  localparam int PipeLatency   = 64;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [lkb_pkg::ApbAddrW-1:0] paddr = '0;
  logic [lkb_pkg::ApbDataW-1:0] pwdata = '0;
  logic [lkb_pkg::ApbDataW-1:0] prdata;
  logic pready;

  lkb_in_if  req_ch ();
  lkb_out_if res_ch ();

  look_direction_to_rotation_basis_top DUT (
    .clk_i, .rst_ni, .in_if(req_ch), .out_if(res_ch),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  lkb_tb_pkg::look_req_t pending_reqs[$];
  lkb_tb_pkg::basis_t    expected_bases[$];
  int unsigned limit_q = 16;
  int  send_idle_pct = 0, recv_stall_pct = 0;
  int  hold_off = 0;
  int  errors = 0;
  int  quiet_cycles = 0;
  bit  stim_done = 1'b0;
  bit  req_accepted = 1'b0;

  // Shift magnitudes below 2^16, then scale each to Q1.14 against the length.
  function automatic bit normalize_vec(input longint v[3], output longint n[3]);
    longint unsigned m[3], mx, len2, s, q, rem, root, bitv;
    int k;
    mx = 0; len2 = 0; k = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = v[i] < 0 ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
    end
    while ((mx >> k) >= 64'd65536) k++;
    for (int i = 0; i < 3; i++) begin
      m[i] = m[i] >> k;
      len2 += m[i] * m[i];
    end
    if (len2 == 0) return 1'b0;
    // Integer square root of len2 << 28, digit by digit.
    rem = len2 << 28; root = 0; bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    s = root;
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << (lkb_pkg::FracBits + 14)) + s / 2) / s;
      if (q > (64'd1 << lkb_pkg::FracBits)) q = 64'd1 << lkb_pkg::FracBits;
      n[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic void cross_vec(input longint a[3], input longint b[3],
                                    output longint c[3]);
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic longint round_q14(input longint v);
    longint unsigned m, q;
    m = v < 0 ? -v : v;
    q = (m + (64'd1 << (lkb_pkg::FracBits - 1))) >> lkb_pkg::FracBits;
    if (q > (64'd1 << lkb_pkg::FracBits)) q = 64'd1 << lkb_pkg::FracBits;
    return v < 0 ? -longint'(q) : longint'(q);
  endfunction

  // Predicts the rotation basis of one request under the current limit.
  function automatic lkb_tb_pkg::basis_t predict_basis(input lkb_tb_pkg::look_req_t r);
    longint d[3], u[3], z[3], c[3], x[3], yv[3], y[3];
    longint lim;
    bit pos;
    lkb_tb_pkg::basis_t b;
    lkb_pkg::status_e st;
    d = '{r.dx, r.dy, r.dz};
    u = '{r.ux, r.uy, r.uz};
    x = '{0, 0, 0}; y = '{0, 0, 0}; z = '{0, 0, 0};
    lim = limit_q;
    st = lkb_pkg::StOk;
    if (!normalize_vec(d, z)) begin
      st = lkb_pkg::StZeroDir;
      z = '{0, 0, 0};
    end else begin
      // Direction near the vertical axis: substitute the up hint.
      if ((z[0] < 0 ? -z[0] : z[0]) < lim && (z[2] < 0 ? -z[2] : z[2]) < lim) begin
        pos = u[1] > 0;
        u[0] = 0; u[1] = 0;
        u[2] = pos ? -z[1] : z[1];
      end
      cross_vec(u, z, c);
      if (!normalize_vec(c, x)) begin
        st = lkb_pkg::StParallel;
        z = '{0, 0, 0};
        x = '{0, 0, 0};
      end else begin
        cross_vec(z, x, yv);
        for (int i = 0; i < 3; i++) y[i] = round_q14(yv[i]);
      end
    end
    b.xx = x[0][15:0]; b.xy = x[1][15:0]; b.xz = x[2][15:0];
    b.yx = y[0][15:0]; b.yy = y[1][15:0]; b.yz = y[2][15:0];
    b.zx = z[0][15:0]; b.zy = z[1][15:0]; b.zz = z[2][15:0];
    b.st = st;
    return b;
  endfunction

  // Driver: offers pending requests at the falling edge.
  initial begin
    req_ch.valid = 1'b0;
    {req_ch.dir_x, req_ch.dir_y, req_ch.dir_z} = '0;
    {req_ch.up_x, req_ch.up_y, req_ch.up_z} = '0;
  end

  // Remembers whether the offered request was taken at the last rising edge.
  always @(posedge clk_i) begin
    req_accepted <= req_ch.valid && req_ch.ready;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!req_ch.valid || req_accepted) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          lkb_tb_pkg::look_req_t r;
          r = pending_reqs.pop_front();
          req_ch.dir_x <= r.dx; req_ch.dir_y <= r.dy; req_ch.dir_z <= r.dz;
          req_ch.up_x <= r.ux; req_ch.up_y <= r.uy; req_ch.up_z <= r.uz;
          req_ch.valid <= 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver backpressure, including long hold-offs.
  initial res_ch.ready = 1'b0;
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  // Monitor: predicts accepted requests and checks accepted results.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (req_ch.valid && req_ch.ready) begin
        lkb_tb_pkg::look_req_t r;
        r = '{req_ch.dir_x, req_ch.dir_y, req_ch.dir_z,
              req_ch.up_x, req_ch.up_y, req_ch.up_z};
        expected_bases.push_back(predict_basis(r));
      end
      if (res_ch.valid && res_ch.ready) begin
        if (expected_bases.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          lkb_tb_pkg::basis_t e;
          e = expected_bases.pop_front();
          if (res_ch.xaxis_x !== e.xx) begin
            $error("xaxis_x expected %0d got %0d", e.xx, res_ch.xaxis_x); errors++;
          end
          if (res_ch.xaxis_y !== e.xy) begin
            $error("xaxis_y expected %0d got %0d", e.xy, res_ch.xaxis_y); errors++;
          end
          if (res_ch.xaxis_z !== e.xz) begin
            $error("xaxis_z expected %0d got %0d", e.xz, res_ch.xaxis_z); errors++;
          end
          if (res_ch.yaxis_x !== e.yx) begin
            $error("yaxis_x expected %0d got %0d", e.yx, res_ch.yaxis_x); errors++;
          end
          if (res_ch.yaxis_y !== e.yy) begin
            $error("yaxis_y expected %0d got %0d", e.yy, res_ch.yaxis_y); errors++;
          end
          if (res_ch.yaxis_z !== e.yz) begin
            $error("yaxis_z expected %0d got %0d", e.yz, res_ch.yaxis_z); errors++;
          end
          if (res_ch.zaxis_x !== e.zx) begin
            $error("zaxis_x expected %0d got %0d", e.zx, res_ch.zaxis_x); errors++;
          end
          if (res_ch.zaxis_y !== e.zy) begin
            $error("zaxis_y expected %0d got %0d", e.zy, res_ch.zaxis_y); errors++;
          end
          if (res_ch.zaxis_z !== e.zz) begin
            $error("zaxis_z expected %0d got %0d", e.zz, res_ch.zaxis_z); errors++;
          end
          if (res_ch.status !== e.st) begin
            $error("status expected %0d got %0d", e.st, res_ch.status); errors++;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any accepted transfer.
  always @(posedge clk_i) begin
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Writes the near-zero limit over APB: setup, then access.
  task automatic write_limit(input int unsigned value);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= lkb_pkg::RegNearZeroAddr; pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    limit_q = value & 32'h7FFF;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic add_req(input int dx, dy, dz, ux, uy, uz);
    lkb_tb_pkg::look_req_t r;
    r = '{16'(dx), 16'(dy), 16'(dz), 16'(ux), 16'(uy), 16'(uz)};
    pending_reqs.push_back(r);
  endtask

  function automatic logic [15:0] rand_field();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(8)) - 16'd4;
      3: return 16'($urandom_range(400)) - 16'd200;
      default: return 16'($urandom);
    endcase
  endfunction

  // Random requests: mostly generic, some near-vertical and parallel cases.
  task automatic add_random(input int count);
    int m;
    logic [15:0] a, b, c;
    for (int i = 0; i < count; i++) begin
      a = rand_field(); b = rand_field(); c = rand_field();
      case ($urandom_range(9))
        0: add_req(0, 0, 0, rand_field(), rand_field(), rand_field());
        1: begin
          m = $urandom_range(1, 3);
          add_req($signed(a), $signed(b), $signed(c),
                  $signed(a) / m, $signed(b) / m, $signed(c) / m);
        end
        2, 3: add_req($urandom_range(40) - 20, $signed(b) | 16'sd1,
                      $urandom_range(40) - 20, rand_field(), rand_field(), rand_field());
        default: add_req($signed(a), $signed(b), $signed(c),
                         $signed(rand_field()), $signed(rand_field()),
                         $signed(rand_field()));
      endcase
    end
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || req_ch.valid || expected_bases.size() > 0)
      @(posedge clk_i);
    repeat (PipeLatency + 4) @(posedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes, zero direction, parallel up, near-vertical substitution.
    add_req(0, 0, 0, 0, 1, 0);
    add_req(0, 0, 1, 0, 1, 0);
    add_req(1, 0, 0, 0, 1, 0);
    add_req(0, 1, 0, 0, 1, 0);
    add_req(0, -1, 0, 0, -1, 0);
    add_req(0, 5, 0, 0, 0, 0);
    add_req(3, 4, 5, 6, 8, 10);
    add_req(-32768, -32768, -32768, 32767, 32767, 32767);
    add_req(32767, 32767, 32767, -32768, -32768, -32768);
    add_req(-32768, 0, 0, 0, -32768, 0);
    add_req(32767, -32768, 32767, 0, 32767, 0);
    add_req(1, 1000, 1, 0, 1, 0);
    add_req(1, 1000, 1, 0, -1, 0);
    add_req(-1, -32768, 0, 5, 0, 5);
    add_req(2, 2048, 0, 0, 3, 0);
    add_req(16'hAAAA, 16'h5555, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h0001);
    drain();

    // Phases under different limits and idling mixes.
    write_limit(0);
    add_random(250); drain();
    write_limit(32'h7FFF);
    send_idle_pct = 65; add_random(300); drain();
    write_limit(16384);
    send_idle_pct = 0; recv_stall_pct = 65; add_random(300); drain();
    write_limit(16);
    // Long receiver hold-off while requests keep coming.
    recv_stall_pct = 0; hold_off = 300; add_random(200); drain();
    write_limit(300);
    send_idle_pct = 18; recv_stall_pct = 18; add_random(300); drain();
    write_limit($urandom_range(16384));
    send_idle_pct = 0; recv_stall_pct = 0; add_random(300); drain();
    write_limit(1);
    send_idle_pct = 65; recv_stall_pct = 65; add_random(300); drain();

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
